FILE: hdl/clash_masked_grid_dot_product_macros.svh
// ----------------------------------------------------------------------------
// clash masked grid dot product - assertion macros
// concurrent check helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef CLASH_MASKED_GRID_DOT_PRODUCT_MACROS_SVH
`define CLASH_MASKED_GRID_DOT_PRODUCT_MACROS_SVH

`ifndef SYNTH
`define CMGDP_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("cmgdp assertion failed");
`define CMGDP_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("cmgdp forbidden condition");
`else
`define CMGDP_ASSERT(label, clk, rstn, prop)
`define CMGDP_NEVER(label, clk, rstn, cond)
`endif

`endif

FILE: hdl/cmgdp_pkg.sv
// ----------------------------------------------------------------------------
// cmgdp_pkg
// shared types and constants of the clash masked grid dot product
// ----------------------------------------------------------------------------
`default_nettype none

package cmgdp_pkg;

    localparam int LANE_W      = 16;
    localparam int FIELD_LANES = 4;
    localparam int TDATA_W     = 2 * FIELD_LANES * LANE_W;
    localparam int ACC_W       = 64;
    localparam int PROD_W      = 2 * LANE_W;
    localparam int PEN_W       = 10;
    localparam int PENPROD_W   = PEN_W + 1 + LANE_W;
    localparam int CONTRIB_W   = 36;
    localparam int PEN_SHIFT   = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam int DEF_CHANNELS = 16;
    localparam int DEF_LANES    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_DRUG_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POCKET_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PENALTY    = 2'd2;

    localparam logic signed [LANE_W-1:0] DRUG_THR_RST   = 16'sd13;
    localparam logic signed [LANE_W-1:0] POCKET_THR_RST = 16'sd6;
    localparam logic [PEN_W-1:0]         PENALTY_RST    = 10'd500;

    typedef logic signed [LANE_W-1:0] sample_t;

    typedef struct packed {
        sample_t [FIELD_LANES-1:0] pocket;
        sample_t [FIELD_LANES-1:0] drug;
        logic                      penalize;
        logic                      skip;
        logic                      last;
    } item_t;

endpackage

`default_nettype wire

FILE: hdl/clash_masked_grid_dot_product.sv
// a result passes the item queue, stage s1, stage s2 and the output register
// throughput: one item per cycle, one score per grid
// the front stalls only when the 4-entry item queue is full, i.e. when the
// score output is held by m_tready low
// reset: synchronous active-low aresetn clears score, voxel position, queue
// and output; thresholds and penalty return to 13, 6 and 500
// ----------------------------------------------------------------------------
// clash_masked_grid_dot_product
// clash masked inner product of pocket and drug voxel grids, saturating score
// ----------------------------------------------------------------------------
`default_nettype none

module clash_masked_grid_dot_product #(
    parameter int CHANNELS = cmgdp_pkg::DEF_CHANNELS,
    parameter int LANES    = cmgdp_pkg::DEF_LANES
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // pocket_lane0..3, drug_lane0..3, 16 bits each from bit 0 up
    input  wire  [cmgdp_pkg::TDATA_W-1:0]      s_tdata,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire                                s_tlast,
    // score
    output logic [cmgdp_pkg::ACC_W-1:0]        m_tdata,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [cmgdp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [cmgdp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cmgdp_pkg::*;

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_not_empty;
    item_t             q_in_item;
    item_t             q_head_item;
    logic [PEN_W-1:0]  penalty;

    cmgdp_front #(
        .CHANNELS (CHANNELS),
        .LANES    (LANES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_in_item),
        .penalty   (penalty)
    );

    cmgdp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (q_head_item),
        .not_empty (q_not_empty)
    );

    cmgdp_back #(
        .LANES (LANES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_item (q_head_item),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .penalty   (penalty),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

FILE: hdl/cmgdp_front.sv
// ----------------------------------------------------------------------------
// cmgdp_front
// accepts items, holds configuration, tracks voxel position and clash state
// ----------------------------------------------------------------------------
`default_nettype none

module cmgdp_front #(
    parameter int CHANNELS = cmgdp_pkg::DEF_CHANNELS,
    parameter int LANES    = cmgdp_pkg::DEF_LANES
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [cmgdp_pkg::TDATA_W-1:0]      s_tdata,
    input  wire                                s_tlast,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [cmgdp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [cmgdp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire                                q_full,
    output logic                               q_push,
    output cmgdp_pkg::item_t                   q_item,
    output logic [cmgdp_pkg::PEN_W-1:0]        penalty
);
    import cmgdp_pkg::*;

    localparam int GROUPS = (CHANNELS + LANES - 1) / LANES;
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    sample_t             drug_thr_reg;
    sample_t             pocket_thr_reg;
    logic [PEN_W-1:0]    penalty_reg;
    logic [GW-1:0]       group_reg, group_next;
    logic                clash_reg, clash_next;
    logic                first;
    logic                clash_now;
    logic                clash_eff;
    logic                accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign penalty   = penalty_reg;

    always_comb begin
        for (int i = 0; i < FIELD_LANES; i++) begin
            q_item.pocket[i] = s_tdata[i*LANE_W +: LANE_W];
            q_item.drug[i]   = s_tdata[(FIELD_LANES+i)*LANE_W +: LANE_W];
        end
        first     = (group_reg == '0);
        clash_now = first && (q_item.drug[0] > drug_thr_reg)
                          && (q_item.pocket[0] < pocket_thr_reg);
        clash_eff = first ? clash_now : clash_reg;
        q_item.penalize = clash_now;
        q_item.skip     = clash_eff;
        q_item.last     = s_tlast;
        q_push          = accept;
    end

    always_comb begin
        group_next = group_reg;
        clash_next = clash_reg;
        if (accept) begin
            if (s_tlast) begin
                group_next = '0;
                clash_next = 1'b0;
            end else begin
                clash_next = clash_eff;
                if (group_reg == GW'(GROUPS - 1)) begin
                    group_next = '0;
                end else begin
                    group_next = group_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drug_thr_reg   <= DRUG_THR_RST;
            pocket_thr_reg <= POCKET_THR_RST;
            penalty_reg    <= PENALTY_RST;
            group_reg      <= '0;
            clash_reg      <= 1'b0;
        end else begin
            group_reg <= group_next;
            clash_reg <= clash_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DRUG_THR:   drug_thr_reg   <= cfg_data;
                    REG_POCKET_THR: pocket_thr_reg <= cfg_data;
                    REG_PENALTY:    penalty_reg    <= cfg_data[PEN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

`include "clash_masked_grid_dot_product_macros.svh"

    // end of grid restarts the voxel
    `CMGDP_ASSERT(a_last_restarts, aclk, aresetn, (accept && s_tlast) |=> (group_reg == '0 && !clash_reg))
    // a penalty only ever comes with the first item of a voxel
    `CMGDP_NEVER(a_penalty_first, aclk, aresetn, accept && q_item.penalize && (group_reg != '0))

endmodule

`default_nettype wire

FILE: hdl/cmgdp_queue.sv
// ----------------------------------------------------------------------------
// cmgdp_queue
// small fifo of classified items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module cmgdp_queue (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  wire cmgdp_pkg::item_t push_item,
    output logic                full,
    input  wire                 pop,
    output cmgdp_pkg::item_t    head_item,
    output logic                not_empty
);
    import cmgdp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t           mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

`include "clash_masked_grid_dot_product_macros.svh"

    `CMGDP_NEVER(a_no_overflow, aclk, aresetn, push && full)
    `CMGDP_NEVER(a_no_underflow, aclk, aresetn, pop && !not_empty)
    `CMGDP_ASSERT(a_ptr_gap, aclk, aresetn, (!not_empty || full) |-> (wr_ptr_reg == rd_ptr_reg))

endmodule

`default_nettype wire

FILE: hdl/cmgdp_back.sv
// ----------------------------------------------------------------------------
// cmgdp_back
// lane products, item contribution and saturating score accumulation
// ----------------------------------------------------------------------------
`default_nettype none

module cmgdp_back #(
    parameter int LANES = cmgdp_pkg::DEF_LANES
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire cmgdp_pkg::item_t            head_item,
    input  wire                              not_empty,
    output logic                             pop,
    input  wire  [cmgdp_pkg::PEN_W-1:0]      penalty,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [cmgdp_pkg::ACC_W-1:0]      m_tdata
);
    import cmgdp_pkg::*;

    localparam int ACTIVE = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;

    logic                              advance;
    logic                              s1_valid_reg;
    logic signed [PROD_W-1:0]          s1_prod_reg [FIELD_LANES];
    logic signed [PENPROD_W-1:0]       s1_pen_reg;
    logic                              s1_penalize_reg;
    logic                              s1_skip_reg;
    logic                              s1_last_reg;
    logic                              s2_valid_reg;
    logic signed [CONTRIB_W-1:0]       s2_contrib_reg, s2_contrib_next;
    logic                              s2_last_reg;
    logic signed [ACC_W-1:0]           acc_reg;
    logic signed [ACC_W:0]             acc_sum;
    logic signed [ACC_W-1:0]           acc_sat;
    logic                              m_tvalid_reg;
    logic [ACC_W-1:0]                  m_tdata_reg;

    assign advance  = !m_tvalid_reg || m_tready;
    assign pop      = advance && not_empty;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        s2_contrib_next = '0;
        if (!s1_skip_reg) begin
            for (int i = 0; i < ACTIVE; i++) begin
                s2_contrib_next = s2_contrib_next + CONTRIB_W'(s1_prod_reg[i]);
            end
        end
        if (s1_penalize_reg) begin
            s2_contrib_next = s2_contrib_next - (CONTRIB_W'(s1_pen_reg) <<< PEN_SHIFT);
        end
    end

    always_comb begin
        acc_sum = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(s2_contrib_reg);
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < FIELD_LANES; i++) begin
                s1_prod_reg[i] <= $signed(head_item.pocket[i]) * $signed(head_item.drug[i]);
            end
            s1_pen_reg      <= $signed({1'b0, penalty}) * $signed(head_item.drug[0]);
            s1_penalize_reg <= head_item.penalize;
            s1_skip_reg     <= head_item.skip;
            s1_last_reg     <= head_item.last;
            s2_contrib_reg  <= s2_contrib_next;
            s2_last_reg     <= s1_last_reg;
            if (s2_valid_reg && s2_last_reg) begin
                m_tdata_reg <= acc_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= not_empty;
            s2_valid_reg <= s1_valid_reg;
            m_tvalid_reg <= s2_valid_reg && s2_last_reg;
            if (s2_valid_reg) begin
                acc_reg <= s2_last_reg ? '0 : acc_sat;
            end
        end
    end

`include "clash_masked_grid_dot_product_macros.svh"

    // the score restarts from zero after each emitted grid
    `CMGDP_ASSERT(a_acc_cleared, aclk, aresetn, (advance && s2_valid_reg && s2_last_reg) |=> (acc_reg == '0))
    // a result appears only from a grid end in the last stage
    `CMGDP_ASSERT(a_result_source, aclk, aresetn, $rose(m_tvalid_reg) |-> $past(s2_valid_reg && s2_last_reg))

endmodule

`default_nettype wire
